>>> design/ate_pkg.sv
// Shared types and codes for the array table engine.
// Holds command and status codes, the beat structs and the compare flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ate_pkg;

	// default table geometry
	localparam int DEPTH_DEF     = 256;
	localparam int WORD_BITS_DEF = 32;

	// command codes
	localparam logic [2:0] CMD_INSERT    = 3'd0;
	localparam logic [2:0] CMD_SEARCH    = 3'd1;
	localparam logic [2:0] CMD_DELETE    = 3'd2;
	localparam logic [2:0] CMD_SORT_ASC  = 3'd3;
	localparam logic [2:0] CMD_SORT_DESC = 3'd4;
	localparam logic [2:0] CMD_READ      = 3'd5;

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd3;

	// request beat
	typedef struct packed {
		logic [2:0]         cmd;
		logic signed [31:0] value;
		logic [8:0]         index;
	} req_t;

	// response beat
	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic signed [31:0] data_out;
		logic [8:0]         position;
		logic [8:0]         entry_count;
	} rsp_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_flags_t;

endpackage

`default_nettype wire

>>> design/array_table_engine.sv
// Top level of the array table engine: command sequencer and output register.
// Depends on ate_pkg, ate_store and ate_cmp.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one command beat:
//   insert, search, delete, sort ascending, sort descending or indexed read.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one beat
//   per command with status, found flag, data, 1-based position and count.
//   Insert, unused codes and misses on an empty table finish without a table
//   scan; read waits on the registered read port; search scans from position
//   1 until a hit or the end; delete searches, then shifts the later entries
//   down; sort is an exchange sort with one read per compare.
//   Reads use the single memory read port; scans and sorts use the shared
//   compare unit. One command is in work at a time; req_stall is high
//   while it runs. A new command is taken as soon as the previous result
//   sits in the output register, even if the receiver stalls it; a later
//   result then waits in the sequencer until the register drains.
//   Reset empties the table (count cleared); storage is not cleared and
//   is only read at positions written since.
`timescale 1ns / 1ps
`default_nettype none

module array_table_engine #(
	parameter int DEPTH     = ate_pkg::DEPTH_DEF,
	parameter int WORD_BITS = ate_pkg::WORD_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ate_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ate_pkg::rsp_t      rsp
);

	import ate_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 9) ? CW : 9;

	// sequencer states
	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_SCAN_RD   = 4'd1;
	localparam logic [3:0] ST_SCAN_CMP  = 4'd2;
	localparam logic [3:0] ST_SHIFT_RD  = 4'd3;
	localparam logic [3:0] ST_SHIFT_WR  = 4'd4;
	localparam logic [3:0] ST_READ_WAIT = 4'd5;
	localparam logic [3:0] ST_SORT_A    = 4'd6;
	localparam logic [3:0] ST_SORT_AL   = 4'd7;
	localparam logic [3:0] ST_SORT_BR   = 4'd8;
	localparam logic [3:0] ST_SORT_BC   = 4'd9;
	localparam logic [3:0] ST_SORT_AW   = 4'd10;
	localparam logic [3:0] ST_DONE      = 4'd11;

	logic [3:0]           state_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        k_q;
	logic [CW-1:0]        b_q;
	logic [WORD_BITS-1:0] ea_q;
	logic [2:0]           cmd_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 accept;
	logic                 load_rsp;
	logic [WORD_BITS-1:0] word_in;
	logic [CW-1:0]        kp1;
	logic [CW-1:0]        bp1;
	logic                 kp1_lt;
	logic                 kp2_lt;
	logic                 bp1_lt;
	logic                 has_room;
	logic                 idx_ok;
	rsp_t                 idle_res;
	logic [3:0]           idle_state;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	logic [WORD_BITS-1:0] op_a;
	logic [WORD_BITS-1:0] op_b;
	cmp_flags_t           flags;

	ate_store #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_store (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	ate_cmp #(
		.WORD_BITS (WORD_BITS)
	) u_cmp (
		.op_a  (op_a),
		.op_b  (op_b),
		.flags (flags)
	);

	// handshake and loop bounds
	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);
	assign word_in   = WORD_BITS'($unsigned(req.value));
	assign kp1       = k_q + CW'(1);
	assign bp1       = b_q + CW'(1);
	assign kp1_lt    = ((CW + 1)'(k_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
	assign kp2_lt    = ((CW + 1)'(k_q) + (CW + 1)'(2)) < (CW + 1)'(count_q);
	assign bp1_lt    = ((CW + 1)'(b_q) + (CW + 1)'(1)) < (CW + 1)'(count_q);
	assign has_room  = count_q < CW'(DEPTH);
	assign idx_ok    = (req.index != 9'd0) && (XW'(req.index) <= XW'(count_q));

	// result and next step of a command taken from idle
	always_comb begin
		idle_res             = '0;
		idle_res.entry_count = 9'(count_q);
		idle_state           = ST_DONE;
		case (req.cmd)
			CMD_INSERT: begin
				idle_res.data_out = 32'(word_in);
				if (has_room) begin
					idle_res.position    = 9'(count_q + CW'(1));
					idle_res.entry_count = 9'(count_q + CW'(1));
				end else begin
					idle_res.status = STATUS_FULL;
				end
			end
			CMD_SEARCH, CMD_DELETE: begin
				if (count_q == '0) begin
					idle_res.status = STATUS_NOT_FOUND;
				end else begin
					idle_state = ST_SCAN_RD;
				end
			end
			CMD_SORT_ASC, CMD_SORT_DESC: begin
				if (count_q > CW'(1)) begin
					idle_state = ST_SORT_A;
				end
			end
			CMD_READ: begin
				if (idx_ok) begin
					idle_res.found    = 1'b1;
					idle_res.position = req.index;
					idle_state        = ST_READ_WAIT;
				end else begin
					idle_res.status = STATUS_BAD_INDEX;
				end
			end
			default: begin
			end
		endcase
	end

	// steer compare operands: scan tests equality against the held key,
	// sort asks whether the pair is out of order
	always_comb begin
		if (cmd_q == CMD_SORT_ASC) begin
			op_a = ea_q;
			op_b = mem_rdata;
		end else begin
			op_a = mem_rdata;
			op_b = ea_q;
		end
	end

	// drive the memory ports from the current step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = k_q[AW-1:0];
		mem_wdata = ea_q;
		mem_raddr = k_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept && req.cmd == CMD_INSERT && has_room) begin
					mem_we    = 1'b1;
					mem_waddr = count_q[AW-1:0];
					mem_wdata = word_in;
				end
				mem_raddr = AW'(req.index - 9'd1);
			end
			ST_SHIFT_RD: begin
				mem_raddr = kp1[AW-1:0];
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			ST_SORT_BR: begin
				mem_raddr = b_q[AW-1:0];
			end
			ST_SORT_BC: begin
				mem_we    = flags.gt;
				mem_waddr = b_q[AW-1:0];
			end
			ST_SORT_AW: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= req.cmd;
						ea_q    <= word_in;
						k_q     <= '0;
						res_q   <= idle_res;
						state_q <= idle_state;
						if (req.cmd == CMD_INSERT && has_room) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_READ_WAIT: begin
					res_q.data_out <= 32'(mem_rdata);
					state_q        <= ST_DONE;
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					if (flags.eq) begin
						res_q.found    <= 1'b1;
						res_q.data_out <= 32'(mem_rdata);
						res_q.position <= 9'(kp1);
						if (cmd_q == CMD_DELETE && kp1_lt) begin
							state_q <= ST_SHIFT_RD;
						end else begin
							if (cmd_q == CMD_DELETE) begin
								count_q           <= count_q - CW'(1);
								res_q.entry_count <= 9'(count_q - CW'(1));
							end
							state_q <= ST_DONE;
						end
					end else if (kp1_lt) begin
						k_q     <= kp1;
						state_q <= ST_SCAN_RD;
					end else begin
						res_q.status <= STATUS_NOT_FOUND;
						state_q      <= ST_DONE;
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					k_q <= kp1;
					if (kp2_lt) begin
						state_q <= ST_SHIFT_RD;
					end else begin
						count_q           <= count_q - CW'(1);
						res_q.entry_count <= 9'(count_q - CW'(1));
						state_q           <= ST_DONE;
					end
				end
				ST_SORT_A: begin
					state_q <= ST_SORT_AL;
				end
				ST_SORT_AL: begin
					ea_q    <= mem_rdata;
					b_q     <= kp1;
					state_q <= ST_SORT_BR;
				end
				ST_SORT_BR: begin
					state_q <= ST_SORT_BC;
				end
				ST_SORT_BC: begin
					// swap: the smaller (or larger) word moves into the held slot
					if (flags.gt) begin
						ea_q <= mem_rdata;
					end
					if (bp1_lt) begin
						b_q     <= bp1;
						state_q <= ST_SORT_BR;
					end else begin
						state_q <= ST_SORT_AW;
					end
				end
				ST_SORT_AW: begin
					if (kp2_lt) begin
						k_q     <= kp1;
						state_q <= ST_SORT_A;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_rsp) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the response beat until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

>>> design/ate_store.sv
// Table storage for the array table engine: one write port, one read port.
// Read data is registered. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module ate_store #(
	parameter int DEPTH     = 256,
	parameter int WORD_BITS = 32,
	localparam int AW       = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic [AW-1:0]        raddr,
	output logic      [WORD_BITS-1:0] rdata_q
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/ate_cmp.sv
// Shared compare unit: equality and signed greater-than on two table words.
// Used by search, delete and both sort orders. Depends on ate_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ate_cmp #(
	parameter int WORD_BITS = 32
) (
	input  wire logic [WORD_BITS-1:0] op_a,
	input  wire logic [WORD_BITS-1:0] op_b,
	output ate_pkg::cmp_flags_t       flags
);

	import ate_pkg::*;

	// compare as two's complement words
	always_comb begin
		flags.eq = (op_a == op_b);
		flags.gt = ($signed(op_a) > $signed(op_b));
	end

endmodule

`default_nettype wire

>>> design/ate_chk.sv
// Port-level checker for the array table engine, bound to the top level.
// Depends on ate_pkg and array_table_engine.
`timescale 1ns / 1ps
`default_nettype none

module ate_chk #(
	parameter int DEPTH = ate_pkg::DEPTH_DEF
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_stall,
	input wire ate_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire ate_pkg::rsp_t rsp
);

	import ate_pkg::*;

	// a stalled request beat holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request beat changed while stalled");

	// a stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// an accepted command keeps the request side busy next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken again right after accept");

	// a hit always reports ok and a real position
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.status == STATUS_OK && rsp.position != 9'd0)
		else $error("hit without ok status or position");

	// count never exceeds the table size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.entry_count) <= DEPTH)
		else $error("entry count beyond table depth");

endmodule

bind array_table_engine ate_chk #(.DEPTH(DEPTH)) u_ate_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
